@@ rtl/fdsc_pkg.sv @@
// Shared types and constants for the preamble/length/checksum deframer.
// Depends on nothing; used by frame_deframer_sum_check_top.
package fdsc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned LEN_W   = 7;
   localparam int unsigned CSR_W   = 1;

   localparam logic [CSR_W-1:0] CSR_FIRST_SYNC  = 1'b0;
   localparam logic [CSR_W-1:0] CSR_SECOND_SYNC = 1'b1;

   typedef enum logic [2:0] {
      ST_HUNT_A,
      ST_HUNT_B,
      ST_ID,
      ST_LEN,
      ST_PAYLOAD,
      ST_CHECK,
      ST_DRAIN_RD,
      ST_DRAIN_LD
   } state_type;

endpackage

@@ rtl/frame_deframer_sum_check_top.sv @@
// Deframer: hunts a two-byte preamble, stores the payload and checks its sum.
// Depends on fdsc_pkg for the state type, register indexes and field widths.
//
// Usage:
//   req_* carries one received byte per item; rsp_* carries one payload byte
//   per item, tagged with id, index, length and an end-of-frame flag.
//   Both channels use valid/stall; an item moves when valid is high and stall
//   is low. csr_* writes the two preamble bytes (index 0 first, 1 second);
//   the user must write them only while the block is idle, as the block does not enforce it.
//   Header and payload bytes are accepted whenever req_valid is high. After a
//   checksum that matches, the payload is drained from the store, each item
//   by a store read and then a load of the output register; the read waits
//   while the receiver stalls, and req_stall is high for the whole drain.
//   A checksum that does not match, or a length above BUFFER_DEPTH, drops the
//   frame with no result. The last result may still wait in the output
//   register while hunting for the next frame resumes.
//   Reset clears the preamble bytes to 0, returns to the hunt and empties the
//   output register; the payload store is not cleared, and needs no sweep.
module frame_deframer_sum_check_top #(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_wr_en,
   input  logic [fdsc_pkg::CSR_W-1:0]    csr_index,
   input  logic [fdsc_pkg::BYTE_W-1:0]   csr_wr_data,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fdsc_pkg::BYTE_W-1:0]   req_rx_byte,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fdsc_pkg::BYTE_W-1:0]   rsp_frame_id,
   output logic [fdsc_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic [fdsc_pkg::INDEX_W-1:0]  rsp_byte_index,
   output logic [fdsc_pkg::LEN_W-1:0]    rsp_frame_length,
   output logic                          rsp_last_of_frame
);

   localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [fdsc_pkg::BYTE_W-1:0] DEPTH_B = fdsc_pkg::BYTE_W'(BUFFER_DEPTH);

   fdsc_pkg::state_type state_ff, state_in;

   logic [fdsc_pkg::BYTE_W-1:0]  sync_a_ff, sync_b_ff;
   logic [fdsc_pkg::BYTE_W-1:0]  held_id_ff, held_id_in;
   logic [fdsc_pkg::BYTE_W-1:0]  held_len_ff, held_len_in;
   logic [fdsc_pkg::LEN_W-1:0]   count_ff, count_in;
   logic [fdsc_pkg::BYTE_W-1:0]  sum_ff, sum_in;
   logic [fdsc_pkg::INDEX_W-1:0] idx_ff, idx_in;

   logic [fdsc_pkg::BYTE_W-1:0]  mem [BUFFER_DEPTH];
   logic [fdsc_pkg::BYTE_W-1:0]  mem_rd_ff;
   logic                         mem_wr_en, mem_rd_en;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fdsc_pkg::BYTE_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [fdsc_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic [fdsc_pkg::INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [fdsc_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         req_take;
   logic [fdsc_pkg::LEN_W-1:0]   count_inc;
   logic                         drain_last;

   assign req_stall = (state_ff == fdsc_pkg::ST_DRAIN_RD) ||
                      (state_ff == fdsc_pkg::ST_DRAIN_LD);
   assign req_take  = req_valid && !req_stall;
   assign count_inc = count_ff + fdsc_pkg::LEN_W'(1);
   assign drain_last = (held_len_ff == 8'd0) ||
                       ({2'b00, idx_ff} == (held_len_ff - 8'd1));

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_id      = rsp_id_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_byte_index    = rsp_idx_ff;
   assign rsp_frame_length  = rsp_len_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_a_ff <= '0;
         sync_b_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fdsc_pkg::CSR_FIRST_SYNC:  sync_a_ff <= csr_wr_data;
            fdsc_pkg::CSR_SECOND_SYNC: sync_b_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      held_id_in   = held_id_ff;
      held_len_in  = held_len_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         fdsc_pkg::ST_HUNT_A: begin
            if (req_take && req_rx_byte == sync_a_ff) state_in = fdsc_pkg::ST_HUNT_B;
         end
         fdsc_pkg::ST_HUNT_B: begin
            if (req_take) begin
               state_in = (req_rx_byte == sync_b_ff) ? fdsc_pkg::ST_ID
                                                     : fdsc_pkg::ST_HUNT_A;
            end
         end
         fdsc_pkg::ST_ID: begin
            if (req_take) begin
               held_id_in = req_rx_byte;
               state_in   = fdsc_pkg::ST_LEN;
            end
         end
         fdsc_pkg::ST_LEN: begin
            if (req_take) begin
               held_len_in = req_rx_byte;
               count_in    = '0;
               sum_in      = '0;
               if (req_rx_byte == 8'd0)      state_in = fdsc_pkg::ST_CHECK;
               else if (req_rx_byte > DEPTH_B) state_in = fdsc_pkg::ST_HUNT_A;
               else                          state_in = fdsc_pkg::ST_PAYLOAD;
            end
         end
         fdsc_pkg::ST_PAYLOAD: begin
            if (req_take) begin
               mem_wr_en = 1'b1;
               sum_in    = sum_ff + req_rx_byte;
               count_in  = count_inc;
               if ({1'b0, count_inc} >= held_len_ff) state_in = fdsc_pkg::ST_CHECK;
            end
         end
         fdsc_pkg::ST_CHECK: begin
            if (req_take) begin
               idx_in   = '0;
               state_in = (req_rx_byte == sum_ff) ? fdsc_pkg::ST_DRAIN_RD
                                                  : fdsc_pkg::ST_HUNT_A;
            end
         end
         fdsc_pkg::ST_DRAIN_RD: begin
            // wait for the output register to free before reading the store
            if (!rsp_valid_ff || !rsp_stall) begin
               mem_rd_en = 1'b1;
               state_in  = fdsc_pkg::ST_DRAIN_LD;
            end
         end
         fdsc_pkg::ST_DRAIN_LD: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = held_id_ff;
            rsp_byte_in  = (held_len_ff == 8'd0) ? 8'd0 : mem_rd_ff;
            rsp_idx_in   = idx_ff;
            rsp_len_in   = held_len_ff[fdsc_pkg::LEN_W-1:0];
            rsp_last_in  = drain_last;
            idx_in       = idx_ff + fdsc_pkg::INDEX_W'(1);
            state_in     = drain_last ? fdsc_pkg::ST_HUNT_A : fdsc_pkg::ST_DRAIN_RD;
         end
         default: state_in = fdsc_pkg::ST_HUNT_A;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdsc_pkg::ST_HUNT_A;
         held_id_ff   <= '0;
         held_len_ff  <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_id_ff   <= held_id_in;
         held_len_ff  <= held_len_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff   <= rsp_id_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) mem[count_ff[AW-1:0]] <= req_rx_byte;
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) mem_rd_ff <= mem[idx_ff[AW-1:0]];
   end

endmodule
